// ===== hw/rtl/wad_pkg.sv =====
package wad_pkg;

   localparam int COEF_WIDTH    = 32;
   localparam int TAP_WIDTH     = 32;
   localparam int ACC_WIDTH     = 64;
   localparam int TRANS_WIDTH   = 16;
   localparam int RES_IN_WIDTH  = 7;
   localparam int RES_OUT_WIDTH = 8;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int FRAC_SHIFT    = 30;

   // per-result tag that rides along the multiply-accumulate pipeline
   typedef struct packed {
      logic [TRANS_WIDTH-1:0]   translation;
      logic [RES_OUT_WIDTH-1:0] resolution;
      logic                     last;
   } meta_type;

   // add with clamp to the signed 64-bit limits
   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] a,
      input logic signed [ACC_WIDTH-1:0] b
   );
      logic [ACC_WIDTH:0]          sum;
      logic signed [ACC_WIDTH-1:0] res;
      sum = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
         res = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                              : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         res = sum[ACC_WIDTH-1:0];
      end
      return res;
   endfunction

   // Q18.46 to Q16.16, round half up, clamp to 32 bits
   function automatic logic signed [COEF_WIDTH-1:0] round_sat(
      input logic signed [ACC_WIDTH-1:0] acc
   );
      logic signed [ACC_WIDTH-FRAC_SHIFT:0] q;
      logic signed [ACC_WIDTH-1:0]          shifted;
      logic signed [COEF_WIDTH-1:0]         res;
      shifted = acc >>> FRAC_SHIFT;
      q = (ACC_WIDTH-FRAC_SHIFT+1)'(shifted)
          + $signed({{(ACC_WIDTH-FRAC_SHIFT){1'b0}}, acc[FRAC_SHIFT-1]});
      if (q[ACC_WIDTH-FRAC_SHIFT:COEF_WIDTH-1] != {(ACC_WIDTH-FRAC_SHIFT-COEF_WIDTH+2){1'b0}}
          && q[ACC_WIDTH-FRAC_SHIFT:COEF_WIDTH-1]
             != {(ACC_WIDTH-FRAC_SHIFT-COEF_WIDTH+2){1'b1}}) begin
         res = q[ACC_WIDTH-FRAC_SHIFT] ? {1'b1, {(COEF_WIDTH-1){1'b0}}}
                                       : {1'b0, {(COEF_WIDTH-1){1'b1}}};
      end else begin
         res = q[COEF_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/wavelet_approximation_decimator.sv =====
// Low-pass wavelet analysis with decimation by two.
// req channel: one scaling coefficient per request at consecutive translations;
//   only the first request of a set supplies translation and resolution, and
//   req_tlast marks the final coefficient of the set.
// rsp channel: coarser coefficients a[k] = sum of c[2k+i]*h[i] over the taps,
//   in ascending k, with rsp_tlast on the final one of the set.
// csr channel: taps written by index 0..7, Q2.30; indexes at or beyond
//   TAP_COUNT are accepted and have no effect. Always ready.
// Pipeline: a result that a request completes passes a product stage, one
//   saturating add per tap and a round stage before it leaves.
// Throughput: one request per cycle while the pipeline accepts. A last
//   request emits up to ceil(TAP_COUNT/2) results, one per cycle through the
//   single multiply-accumulate pipeline while it does not stall, and holds
//   req_tready low for all but the last of them.
// Reset: taps return to zero and no set is in progress; the pipeline empties.
// Stall: a held rsp result does not stop the pipeline from filling its empty
//   stages, so requests keep being taken until every stage is occupied.
module wavelet_approximation_decimator #(
   parameter int TAP_COUNT = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wad_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [wad_pkg::TAP_WIDTH-1:0]          csr_data,
   // request: [31:0] coefficient_in, [47:32] translation_in,
   // [54:48] resolution_in, [55] zero
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [55:0]                            req_tdata,
   input  logic                                   req_tlast,
   // response: [31:0] coefficient_out, [47:32] translation_out,
   // [55:48] resolution_out
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [55:0]                            rsp_tdata,
   output logic                                   rsp_tlast
);

   // most results one set-ending request can produce
   localparam int MAX_OUT     = (TAP_COUNT + 1) / 2;
   localparam int COUNT_WIDTH = $clog2(MAX_OUT + 1);
   // parity of TAP_COUNT-1, sets which translations complete an output
   localparam logic TAP_PARITY = 1'((TAP_COUNT - 1) % 2);

   localparam int CW  = wad_pkg::COEF_WIDTH;
   localparam int TW  = wad_pkg::TRANS_WIDTH;
   localparam int RIW = wad_pkg::RES_IN_WIDTH;
   localparam int ROW = wad_pkg::RES_OUT_WIDTH;

   // request fields
   logic signed [CW-1:0]   req_coef;
   logic [TW-1:0]          req_trans;
   logic [RIW-1:0]         req_res;
   logic                   accept;

   // configuration
   logic signed [wad_pkg::TAP_WIDTH-1:0] taps_ff [TAP_COUNT];

   // set state
   logic signed [CW-1:0]   window_ff [TAP_COUNT];
   logic signed [CW-1:0]   window_in [TAP_COUNT];
   logic [TW-1:0]          translation_ff;
   logic [TW-1:0]          translation_in;
   logic [RIW-1:0]         resolution_ff;
   logic [RIW-1:0]         resolution_in;
   logic                   run_started_ff;
   logic                   run_started_in;

   // pending results of the newest request
   logic signed [CW-1:0]   job_v_ff [TAP_COUNT];
   logic signed [CW-1:0]   job_v_in [TAP_COUNT];
   logic [TW-1:0]          job_k_ff;
   logic [TW-1:0]          job_k_in;
   logic [COUNT_WIDTH-1:0] job_count_ff;
   logic [COUNT_WIDTH-1:0] job_count_in;
   logic                   job_last_ff;
   logic                   job_last_in;
   logic [ROW-1:0]         job_res_ff;
   logic [ROW-1:0]         job_res_in;

   logic                   parity;
   logic [17:0]            kfirst_sum;
   logic [4:0]             count_sum;
   logic [COUNT_WIDTH-1:0] count_new;
   logic                   issue;

   // multiply-accumulate pipeline
   logic                   mac_in_ready;
   logic signed [CW-1:0]   mac_samples [TAP_COUNT];
   wad_pkg::meta_type      mac_in_meta;
   wad_pkg::meta_type      mac_out_meta;
   logic signed [CW-1:0]   mac_out_coef;

   assign req_coef  = req_tdata[31:0];
   assign req_trans = req_tdata[47:32];
   assign req_res   = req_tdata[54:48];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAP_COUNT; i++) begin
            taps_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         for (int i = 0; i < TAP_COUNT; i++) begin
            if (csr_index == wad_pkg::CSR_IDX_WIDTH'(i)) begin
               taps_ff[i] <= csr_data;
            end
         end
      end
   end

   // a new request may enter once the pending results are out or the
   // final one is going into the pipeline this cycle
   assign issue      = (job_count_ff != '0) && mac_in_ready;
   assign req_tready = (job_count_ff == '0)
                       || ((job_count_ff == COUNT_WIDTH'(1)) && mac_in_ready);
   assign accept     = req_tvalid && req_tready;

   // window shift; a new set starts from an all-zero window
   always_comb begin
      for (int m = 0; m < TAP_COUNT; m++) begin
         if (m == 0) begin
            window_in[m] = req_coef;
         end else if (run_started_ff) begin
            window_in[m] = window_ff[(m >= 1) ? m - 1 : 0];
         end else begin
            window_in[m] = '0;
         end
      end
      translation_in = run_started_ff ? translation_ff + TW'(1) : req_trans;
      resolution_in  = run_started_ff ? resolution_ff : req_res;
      run_started_in = !req_tlast;
   end

   // first output index ceil((t-TAP_COUNT+1)/2) and number of outputs
   always_comb begin
      parity     = translation_in[0] ^ TAP_PARITY;
      kfirst_sum = {{2{translation_in[TW-1]}}, translation_in} - 18'(TAP_COUNT - 2);
      count_sum  = 5'(TAP_COUNT + 1) - {4'd0, translation_in[0]} - {4'd0, parity};
      if (req_tlast) begin
         count_new = COUNT_WIDTH'(count_sum >> 1);
      end else begin
         count_new = parity ? '0 : COUNT_WIDTH'(1);
      end
   end

   // job window: tap i reads entry TAP_COUNT-1-i; each result moves it by two
   always_comb begin
      job_k_in     = job_k_ff;
      job_count_in = job_count_ff;
      job_last_in  = job_last_ff;
      job_res_in   = job_res_ff;
      for (int m = 0; m < TAP_COUNT; m++) begin
         job_v_in[m] = job_v_ff[m];
      end
      if (accept && count_new != '0) begin
         job_k_in     = kfirst_sum[16:1];
         job_count_in = count_new;
         job_last_in  = req_tlast;
         job_res_in   = {resolution_in[RIW-1], resolution_in} - ROW'(1);
         for (int m = 0; m < TAP_COUNT; m++) begin
            if (!parity) begin
               job_v_in[m] = window_in[m];
            end else if (m == 0) begin
               job_v_in[m] = '0;
            end else begin
               job_v_in[m] = window_in[(m >= 1) ? m - 1 : 0];
            end
         end
      end else if (issue) begin
         job_k_in     = job_k_ff + TW'(1);
         job_count_in = job_count_ff - COUNT_WIDTH'(1);
         for (int m = 0; m < TAP_COUNT; m++) begin
            job_v_in[m] = (m >= 2) ? job_v_ff[(m >= 2) ? m - 2 : 0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_started_ff <= 1'b0;
         translation_ff <= '0;
         resolution_ff  <= '0;
         job_count_ff   <= '0;
      end else begin
         job_count_ff <= job_count_in;
         if (accept) begin
            run_started_ff <= run_started_in;
            translation_ff <= translation_in;
            resolution_ff  <= resolution_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
      job_v_ff    <= job_v_in;
      job_k_ff    <= job_k_in;
      job_last_ff <= job_last_in;
      job_res_ff  <= job_res_in;
   end

   always_comb begin
      for (int i = 0; i < TAP_COUNT; i++) begin
         mac_samples[i] = job_v_ff[TAP_COUNT - 1 - i];
      end
      mac_in_meta.translation = job_k_ff;
      mac_in_meta.resolution  = job_res_ff;
      mac_in_meta.last        = job_last_ff && (job_count_ff == COUNT_WIDTH'(1));
   end

   wad_mac_pipe #(
      .TAP_COUNT (TAP_COUNT)
   ) u_mac_pipe (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (job_count_ff != '0),
      .in_ready        (mac_in_ready),
      .in_samples      (mac_samples),
      .in_meta         (mac_in_meta),
      .taps            (taps_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_coefficient (mac_out_coef),
      .out_meta        (mac_out_meta)
   );

   assign rsp_tdata = {mac_out_meta.resolution, mac_out_meta.translation, mac_out_coef};
   assign rsp_tlast = mac_out_meta.last;

endmodule

// ===== hw/rtl/wad_mac_pipe.sv =====
module wad_mac_pipe #(
   parameter int TAP_COUNT = 4
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic signed [wad_pkg::COEF_WIDTH-1:0]     in_samples [TAP_COUNT],
   input  wad_pkg::meta_type                         in_meta,
   input  logic signed [wad_pkg::TAP_WIDTH-1:0]      taps [TAP_COUNT],
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic signed [wad_pkg::COEF_WIDTH-1:0]     out_coefficient,
   output wad_pkg::meta_type                         out_meta
);

   // stage 0 holds the products, stage s adds product s-1
   localparam int STAGES = TAP_COUNT + 1;

   logic [STAGES-1:0]                          valid_ff;
   logic [STAGES-1:0]                          valid_in;
   logic [STAGES-1:0]                          stage_ready;
   logic signed [wad_pkg::ACC_WIDTH-1:0]       prod_ff [STAGES][TAP_COUNT];
   logic signed [wad_pkg::ACC_WIDTH-1:0]       acc_ff [STAGES];
   wad_pkg::meta_type                          meta_ff [STAGES];
   logic                                       out_valid_ff;
   logic                                       out_valid_in;
   logic signed [wad_pkg::COEF_WIDTH-1:0]      out_coef_ff;
   wad_pkg::meta_type                          out_meta_ff;
   logic                                       out_free;

   assign out_free = !out_valid_ff || out_ready;

   // a stage takes new data when empty or when it passes its own on
   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || out_free;
      for (int s = STAGES - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_ready[0]) begin
         valid_in[0] = in_valid;
      end
      for (int s = 1; s < STAGES; s++) begin
         if (stage_ready[s]) begin
            valid_in[s] = valid_ff[s-1];
         end
      end
      out_valid_in = out_free ? valid_ff[STAGES-1] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         for (int i = 0; i < TAP_COUNT; i++) begin
            prod_ff[0][i] <= in_samples[i] * taps[i];
         end
         acc_ff[0]  <= '0;
         meta_ff[0] <= in_meta;
      end
      for (int s = 1; s < STAGES; s++) begin
         if (stage_ready[s]) begin
            prod_ff[s] <= prod_ff[s-1];
            acc_ff[s]  <= wad_pkg::sat_add(acc_ff[s-1], prod_ff[s-1][s-1]);
            meta_ff[s] <= meta_ff[s-1];
         end
      end
      if (out_free) begin
         out_coef_ff <= wad_pkg::round_sat(acc_ff[STAGES-1]);
         out_meta_ff <= meta_ff[STAGES-1];
      end
   end

   assign in_ready        = stage_ready[0];
   assign out_valid       = out_valid_ff;
   assign out_coefficient = out_coef_ff;
   assign out_meta        = out_meta_ff;

endmodule

// ===== tb/sv/wavelet_approximation_decimator_tb.sv =====
module wavelet_approximation_decimator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAP_COUNT       = 4;
   localparam int TAP_SLOTS       = 8;
   localparam int RANDOM_REQUESTS = 500;
   // settle time after the last expected result, with margin over the pipeline
   localparam int SETTLE_CYCLES   = TAP_COUNT + 6;

   localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_LO = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
   localparam longint Q16_HI = 64'sd2147483647;
   localparam longint Q16_LO = -64'sd2147483648;

   // directed table row kinds
   typedef enum logic [1:0] {
      ROW_REQUEST,
      ROW_TAP,
      ROW_ALL_TAPS
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   index;       // tap index for ROW_TAP
      logic [31:0]  value;       // coefficient, or tap value
      logic [15:0]  trans;
      logic [6:0]   res;
      logic         last;
      logic         typed;       // coefficient_out of every result is typed in
      logic [31:0]  typed_coef;
   } stim_row_type;

   // one coarse coefficient as it leaves the block
   typedef struct packed {
      logic [31:0] coef;
      logic [15:0] trans;
      logic [7:0]  res;
      logic        last;
   } coarse_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [wad_pkg::CSR_IDX_WIDTH-1:0]  csr_index;
   logic [wad_pkg::TAP_WIDTH-1:0]      csr_data;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [55:0]                        req_tdata;   // coefficient, translation, resolution, zero
   logic                               req_tlast;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [55:0]                        rsp_tdata;   // coefficient, translation, resolution
   logic                               rsp_tlast;

   // expected coarse coefficients, oldest first
   coarse_type coarse_q[$];

   // shadow of the block state
   logic [31:0] tap_shadow    [TAP_SLOTS];
   logic [31:0] window_shadow [TAP_SLOTS];
   logic [15:0] trans_shadow;
   logic [6:0]  res_shadow;
   bit          set_open;

   int mismatch_count;
   int req_gap_max;
   int rsp_stall_max;

   // directed stimulus: after-reset zeros, wraps, saturation, tap patterns
   stim_row_type directed_rows [0:27] = '{
      // taps still zero after reset, everything comes out zero
      '{ROW_REQUEST, 3'd0, 32'h7FFF_FFFF, 16'h0000, 7'h00, 1'b1, 1'b1, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h8000_0000, 16'h7FFF, 7'h3F, 1'b0, 1'b1, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h1234_5678, 16'h0000, 7'h00, 1'b1, 1'b1, 32'h0},
      // most negative taps times most negative data, positive clamp
      '{ROW_ALL_TAPS, 3'd0, 32'h8000_0000, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h8000_0000, 16'hFFFE, 7'h40, 1'b0, 1'b1, 32'h7FFF_FFFF},
      '{ROW_REQUEST, 3'd0, 32'h8000_0000, 16'h0000, 7'h00, 1'b0, 1'b1, 32'h7FFF_FFFF},
      '{ROW_REQUEST, 3'd0, 32'h8000_0000, 16'h0000, 7'h00, 1'b1, 1'b1, 32'h7FFF_FFFF},
      // most positive taps times most negative data, negative clamp
      '{ROW_ALL_TAPS, 3'd0, 32'h7FFF_FFFF, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h8000_0000, 16'h8000, 7'h00, 1'b0, 1'b1, 32'h8000_0000},
      '{ROW_REQUEST, 3'd0, 32'h8000_0000, 16'h0000, 7'h00, 1'b1, 1'b1, 32'h8000_0000},
      // mixed taps, the upper four must have no effect
      '{ROW_TAP, 3'd0, 32'h4000_0000, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd1, 32'h2000_0000, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd2, 32'hC000_0000, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd3, 32'h1000_0000, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd4, 32'h7FFF_FFFF, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd5, 32'h8000_0000, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd6, 32'h1234_5678, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_TAP, 3'd7, 32'hFFFF_FFFF, 16'h0, 7'h0, 1'b0, 1'b0, 32'h0},
      // translation wraps in the middle of a set, ignored fields are noise
      '{ROW_REQUEST, 3'd0, 32'h0001_0000, 16'h7FFD, 7'h3F, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'hFFFF_0000, 16'h0000, 7'h7F, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h7FFF_FFFF, 16'hFFFF, 7'h00, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h0000_0001, 16'h1234, 7'h55, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h0000_8000, 16'hAAAA, 7'h2A, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'hFFFF_FFFF, 16'h5555, 7'h15, 1'b1, 1'b0, 32'h0},
      // single-request sets at even and odd translation
      '{ROW_REQUEST, 3'd0, 32'h0002_0000, 16'h0010, 7'h15, 1'b1, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h0002_8000, 16'h0011, 7'h6A, 1'b1, 1'b0, 32'h0},
      // two-request set starting odd
      '{ROW_REQUEST, 3'd0, 32'hFFFE_0000, 16'h0101, 7'h01, 1'b0, 1'b0, 32'h0},
      '{ROW_REQUEST, 3'd0, 32'h0000_4000, 16'h5555, 7'h2A, 1'b1, 1'b0, 32'h0}
   };

   wavelet_approximation_decimator #(
      .TAP_COUNT(TAP_COUNT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // a[k]: taps against the window, saturating 64-bit sum, round half up to Q16.16
   function automatic logic [31:0] lowpass_at(input int t, input int k);
      logic signed [63:0] acc;
      logic signed [64:0] wide;
      logic signed [63:0] prod;
      logic signed [31:0] sample;
      logic signed [31:0] tap;
      longint             q;
      int                 off;
      acc = '0;
      for (int i = 0; i < TAP_COUNT && i < TAP_SLOTS; i++) begin
         off = t - 2 * k - i;
         if (off >= 0 && off < TAP_SLOTS) begin
            sample = window_shadow[off];
            tap    = tap_shadow[i];
            prod   = sample * tap;
            wide   = acc + prod;
            if (wide > ACC_HI) begin
               acc = ACC_HI;
            end else if (wide < ACC_LO) begin
               acc = ACC_LO;
            end else begin
               acc = wide[63:0];
            end
         end
      end
      q = acc >>> 30;
      if (acc[29]) begin
         q = q + 1;
      end
      if (q > Q16_HI) begin
         q = Q16_HI;
      end else if (q < Q16_LO) begin
         q = Q16_LO;
      end
      return q[31:0];
   endfunction

   // advance the shadow state by one request and queue what it releases
   function automatic void predict_coarse(input logic [31:0] coef, input logic [15:0] tin,
                                          input logic [6:0] rin, input logic last,
                                          input logic typed, input logic [31:0] typed_coef);
      int         t;
      int         d;
      int         k_lo;
      int         k_hi;
      logic [7:0] res_out;
      coarse_type item;
      if (!set_open) begin
         // first request of a set: fresh window, translation and resolution taken
         foreach (window_shadow[i]) window_shadow[i] = '0;
         trans_shadow = tin;
         res_shadow   = rin;
         set_open     = 1'b1;
      end else begin
         trans_shadow = trans_shadow + 16'd1;
      end
      for (int i = TAP_SLOTS - 1; i > 0; i--) begin
         window_shadow[i] = window_shadow[i-1];
      end
      window_shadow[0] = coef;

      t    = int'($signed(trans_shadow));
      d    = t - TAP_COUNT + 1;
      k_lo = -((-d) >>> 1);
      k_hi = last ? (t >>> 1) : (d >>> 1);
      // held resolution minus one in 8 bits, -64 goes to -65
      res_out = {res_shadow[6], res_shadow} - 8'd1;
      for (int k = k_lo; k <= k_hi; k++) begin
         item.coef  = typed ? typed_coef : lowpass_at(t, k);
         item.trans = 16'(k);
         item.res   = res_out;
         item.last  = last && (k == k_hi);
         coarse_q   = {coarse_q, item};
      end
      if (last) begin
         set_open = 1'b0;
      end
   endfunction

   // one request with a random lead-in gap, predicted when taken
   task automatic push_request(input logic [31:0] coef, input logic [15:0] tin,
                               input logic [6:0] rin, input logic last,
                               input logic typed, input logic [31:0] typed_coef);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rin, tin, coef};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_coarse(coef, tin, rin, last, typed, typed_coef);
   endtask

   // leaves csr_valid high, the caller drops it after the last write
   task automatic write_tap(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tap_shadow[idx] = val;
   endtask

   // no request in flight and every coarse coefficient out
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (coarse_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_tap();
      case ($urandom_range(0, 6)) inside
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'h4000_0000;   // 1.0
         [4:5]:   return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_coefficient();
      case ($urandom_range(0, 7)) inside
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         [2:3]:   return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_directed_rows();
      stim_row_type row;
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         case (row.kind)
            ROW_REQUEST: begin
               push_request(row.value, row.trans, row.res, row.last,
                            row.typed, row.typed_coef);
            end
            ROW_TAP: begin
               drain_pipeline();
               write_tap(row.index, row.value);
               csr_valid <= 1'b0;
            end
            ROW_ALL_TAPS: begin
               drain_pipeline();
               for (int i = 0; i < TAP_SLOTS; i++) begin
                  write_tap(3'(i), row.value);
               end
               csr_valid <= 1'b0;
            end
            default: begin
               report_mismatch("bad directed row kind");
            end
         endcase
      end
   endtask

   // random sets of random length, taps and idling redrawn every few sets
   task automatic run_random_sets();
      int          sent;
      int          sets_done;
      int          set_len;
      logic [15:0] start_trans;
      sent      = 0;
      sets_done = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sets_done % 8 == 0) begin
            drain_pipeline();
            for (int i = 0; i < TAP_SLOTS; i++) begin
               write_tap(3'(i), random_tap());
            end
            csr_valid     <= 1'b0;
            req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
            rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         end
         set_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
         case ($urandom_range(0, 3))
            0:       start_trans = 16'h7FF8 + 16'($urandom_range(0, 7));
            1:       start_trans = 16'hFFF8 + 16'($urandom_range(0, 7));
            default: start_trans = 16'($urandom);
         endcase
         for (int j = 0; j < set_len; j++) begin
            // translation and resolution past the first request are noise
            push_request(random_coefficient(),
                         (j == 0) ? start_trans : 16'($urandom),
                         7'($urandom), (j == set_len - 1), 1'b0, 32'h0);
            sent++;
         end
         sets_done++;
      end
   endtask

   // result side: random stalls, each result checked against the oldest expectation
   initial begin
      int         stall;
      coarse_type want;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (coarse_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %h last %b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = coarse_q.pop_front();
            if (rsp_tdata[31:0] !== want.coef) begin
               report_mismatch($sformatf("k %0d coefficient %h, expected %h",
                                         $signed(want.trans), rsp_tdata[31:0], want.coef));
            end
            if (rsp_tdata[47:32] !== want.trans) begin
               report_mismatch($sformatf("translation %h, expected %h",
                                         rsp_tdata[47:32], want.trans));
            end
            if (rsp_tdata[55:48] !== want.res) begin
               report_mismatch($sformatf("k %0d resolution %h, expected %h",
                                         $signed(want.trans), rsp_tdata[55:48], want.res));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("k %0d last %b, expected %b",
                                         $signed(want.trans), rsp_tlast, want.last));
            end
         end
      end
   end

   // main sequence
   initial begin
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      // shadow matches the block right after reset
      foreach (tap_shadow[i]) tap_shadow[i] = '0;
      foreach (window_shadow[i]) window_shadow[i] = '0;
      trans_shadow   = '0;
      res_shadow     = '0;
      set_open       = 1'b0;
      mismatch_count = 0;
      req_gap_max    = 10;
      rsp_stall_max  = 10;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed_rows();
      run_random_sets();

      // let the tail drain, then look for strays
      req_tvalid <= 1'b0;
      while (coarse_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/wad_pkg.sv
hw/rtl/wad_mac_pipe.sv
hw/rtl/wavelet_approximation_decimator.sv
tb/sv/wavelet_approximation_decimator_tb.sv
